// ----- sv/cip_pkg.sv -----
// ----------------------------------------------------------------------------
// cip_pkg
// Shared constants, status codes and the result item type of the inner
// credential unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package cip_pkg;

   // salt bytes skipped ahead of the address length byte
   localparam logic [7:0] SALT_BYTES = 8'd8;
   // the only non-zero origin address length that is accepted
   localparam logic [7:0] ADDR_BYTES = 8'd4;
   localparam logic [7:0] WORD_BYTES = 8'd4;

   // result queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // summary status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_SALT_SHORT  = 4'd1;
   localparam logic [3:0] ST_ALEN_SHORT  = 4'd2;
   localparam logic [3:0] ST_ADDR_SHORT  = 4'd3;
   localparam logic [3:0] ST_ADDR_BAD    = 4'd4;
   localparam logic [3:0] ST_WORD0_SHORT = 4'd5;
   localparam logic [3:0] ST_PAY_SHORT   = 4'd12;
   localparam logic [3:0] ST_TRAILING    = 4'd13;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [3:0]  status;
      logic        addr_present;
      logic [31:0] origin_addr;
      logic [31:0] encode_time;
      logic [31:0] time_to_live;
      logic [31:0] user_id;
      logic [31:0] group_id;
      logic [31:0] allowed_uid;
      logic [31:0] allowed_gid;
      logic [31:0] data_length;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/cip_req_if.sv -----
// ----------------------------------------------------------------------------
// cip_req_if
// Input channel of the inner credential unpacker: one plaintext byte per
// item, with a flag on the last byte of a credential.
// ----------------------------------------------------------------------------
`default_nettype none

interface cip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       final_byte;

   modport source (output valid, output data_in, output final_byte, input ready);
   modport sink   (input valid, input data_in, input final_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/cip_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cip_rsp_if
// Result channel of the inner credential unpacker: a payload byte or the
// summary that ends a credential.
// ----------------------------------------------------------------------------
`default_nettype none

interface cip_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [3:0]  status;
   logic        addr_present;
   logic [31:0] origin_addr;
   logic [31:0] encode_time;
   logic [31:0] time_to_live;
   logic [31:0] user_id;
   logic [31:0] group_id;
   logic [31:0] allowed_uid;
   logic [31:0] allowed_gid;
   logic [31:0] data_length;

   modport source (
      output valid, output kind, output payload_byte, output status,
      output addr_present, output origin_addr, output encode_time,
      output time_to_live, output user_id, output group_id,
      output allowed_uid, output allowed_gid, output data_length,
      input ready
   );
   modport sink (
      input valid, input kind, input payload_byte, input status,
      input addr_present, input origin_addr, input encode_time,
      input time_to_live, input user_id, input group_id,
      input allowed_uid, input allowed_gid, input data_length,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/credential_inner_unpacker.sv -----
// ----------------------------------------------------------------------------
// credential_inner_unpacker
// Parses the decrypted inner credential byte by byte: skips the salt, reads
// the origin address and seven header words, passes payload bytes through
// and closes each credential with a summary item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       item
//  req_if    in   valid / ready   data_in, final_byte
//  rsp_if    out  valid / ready   payload byte or summary (status + header)
//
//  One byte is accepted per cycle while req_if is ready; its results enter a
//  4-entry result queue in the same edge and are offered from the next cycle
//  on. A final byte that is also a payload byte yields two items, drained one
//  per cycle while rsp_if is ready; req_if.ready drops only while fewer than
//  two slots are free, so with rsp_if stalled req_if stops at three items.
//  Synchronous reset clears the parser and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module credential_inner_unpacker (
   input  wire       clock,
   input  wire       reset,
   cip_req_if.sink   req_if,
   cip_rsp_if.source rsp_if
);

   localparam logic [3:0] PH_SALT = 4'd0;
   localparam logic [3:0] PH_ALEN = 4'd1;
   localparam logic [3:0] PH_ADDR = 4'd2;
   localparam logic [3:0] PH_BAD  = 4'd3;
   localparam logic [3:0] PH_W0   = 4'd4;
   localparam logic [3:0] PH_W1   = 4'd5;
   localparam logic [3:0] PH_W2   = 4'd6;
   localparam logic [3:0] PH_W3   = 4'd7;
   localparam logic [3:0] PH_W4   = 4'd8;
   localparam logic [3:0] PH_W5   = 4'd9;
   localparam logic [3:0] PH_W6   = 4'd10;
   localparam logic [3:0] PH_PAY  = 4'd11;
   localparam logic [3:0] PH_DONE = 4'd12;

   localparam int unsigned AW = cip_pkg::QUEUE_AW;
   localparam logic [AW:0] DEPTH      = (AW+1)'(cip_pkg::QUEUE_DEPTH);
   localparam logic [AW:0] READY_MAX  = DEPTH - (AW+1)'(2);

   // parser state
   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [31:0] shift_ff, shift_in;
   logic [7:0]  alen_ff, alen_in;
   logic [31:0] hdr_ff [8];
   logic [31:0] hdr_in [8];
   logic [31:0] rem_ff, rem_in;
   logic [3:0]  err_ff, err_in;

   // step values
   logic [3:0]  ph_cur, ph_nx;
   logic [7:0]  cnt_cur, cnt_nx;
   logic [31:0] shift_nx;
   logic [7:0]  alen_nx;
   logic [31:0] hdr_nx [8];
   logic [31:0] rem_nx;
   logic [3:0]  err_nx;
   logic [2:0]  slot;
   logic        pay_hit;
   logic [3:0]  sum_status;
   logic        have_addr;

   cip_pkg::rsp_type pay_rsp, sum_rsp;

   // result queue
   cip_pkg::rsp_type q_ff [cip_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   count_ff, count_in;
   logic          accept, pop, push_pay, push_sum;
   logic [AW-1:0] sum_addr;

   assign accept = req_if.valid & req_if.ready;
   assign pop    = rsp_if.valid & rsp_if.ready;
   assign req_if.ready = (count_ff <= READY_MAX);

   always_comb begin
      ph_cur   = phase_ff;
      cnt_cur  = cnt_ff;
      if (phase_ff == PH_SALT && cnt_ff >= cip_pkg::SALT_BYTES) begin
         ph_cur  = PH_ALEN;
         cnt_cur = '0;
      end
      ph_nx    = ph_cur;
      cnt_nx   = cnt_cur;
      shift_nx = shift_ff;
      alen_nx  = alen_ff;
      hdr_nx   = hdr_ff;
      rem_nx   = rem_ff;
      err_nx   = err_ff;
      slot     = '0;
      pay_hit  = 1'b0;
      case (ph_cur)
         PH_SALT: begin
            cnt_nx = cnt_cur + 8'd1;
            if (cnt_nx >= cip_pkg::SALT_BYTES) begin
               ph_nx  = PH_ALEN;
               cnt_nx = '0;
            end
         end
         PH_ALEN: begin
            alen_nx  = req_if.data_in;
            cnt_nx   = '0;
            shift_nx = '0;
            if (req_if.data_in == 8'd0) begin
               ph_nx = PH_W0;
            end else if (req_if.data_in == cip_pkg::ADDR_BYTES) begin
               ph_nx = PH_ADDR;
            end else begin
               ph_nx = PH_BAD;
            end
         end
         PH_ADDR, PH_W0, PH_W1, PH_W2, PH_W3, PH_W4, PH_W5, PH_W6: begin
            shift_nx = {shift_ff[23:0], req_if.data_in};
            cnt_nx   = cnt_cur + 8'd1;
            if (cnt_nx >= cip_pkg::WORD_BYTES) begin
               // address lands in slot 0, header word k in slot k+1
               slot = (ph_cur == PH_ADDR) ? 3'd0 : 3'(ph_cur - PH_W0 + 4'd1);
               hdr_nx[slot] = shift_nx;
               cnt_nx = '0;
               if (ph_cur == PH_W6) begin
                  if (shift_nx == 32'd0) begin
                     ph_nx = PH_DONE;
                  end else begin
                     rem_nx = shift_nx;
                     ph_nx  = PH_PAY;
                  end
               end else if (ph_cur == PH_ADDR) begin
                  ph_nx = PH_W0;
               end else begin
                  ph_nx = ph_cur + 4'd1;
               end
               shift_nx = '0;
            end
         end
         PH_BAD: begin
            if (cnt_cur != 8'hFF) begin
               cnt_nx = cnt_cur + 8'd1;
            end
         end
         PH_PAY: begin
            pay_hit = 1'b1;
            rem_nx  = rem_ff - 32'd1;
            if (rem_nx == 32'd0) begin
               ph_nx = PH_DONE;
            end
         end
         default: begin
            // anything past the payload is trailing data
            ph_nx  = PH_DONE;
            err_nx = cip_pkg::ST_TRAILING;
         end
      endcase
   end

   always_comb begin
      case (ph_nx)
         PH_SALT: sum_status = cip_pkg::ST_SALT_SHORT;
         PH_ALEN: sum_status = cip_pkg::ST_ALEN_SHORT;
         PH_ADDR: sum_status = cip_pkg::ST_ADDR_SHORT;
         PH_BAD: begin
            sum_status = (alen_nx > cnt_nx) ? cip_pkg::ST_ADDR_SHORT
                                            : cip_pkg::ST_ADDR_BAD;
         end
         PH_W0, PH_W1, PH_W2, PH_W3, PH_W4, PH_W5, PH_W6: begin
            sum_status = cip_pkg::ST_WORD0_SHORT + (ph_nx - PH_W0);
         end
         PH_PAY:  sum_status = cip_pkg::ST_PAY_SHORT;
         default: sum_status = err_nx;
      endcase
      have_addr = (alen_nx == cip_pkg::ADDR_BYTES) && (ph_nx >= PH_W0) &&
                  (ph_nx <= PH_DONE);
   end

   always_comb begin
      pay_rsp              = '0;
      pay_rsp.kind         = cip_pkg::KIND_PAYLOAD;
      pay_rsp.payload_byte = req_if.data_in;

      sum_rsp              = '0;
      sum_rsp.kind         = cip_pkg::KIND_SUMMARY;
      sum_rsp.status       = sum_status;
      sum_rsp.addr_present = have_addr;
      sum_rsp.origin_addr  = have_addr ? hdr_nx[0] : 32'd0;
      sum_rsp.encode_time  = hdr_nx[1];
      sum_rsp.time_to_live = hdr_nx[2];
      sum_rsp.user_id      = hdr_nx[3];
      sum_rsp.group_id     = hdr_nx[4];
      sum_rsp.allowed_uid  = hdr_nx[5];
      sum_rsp.allowed_gid  = hdr_nx[6];
      sum_rsp.data_length  = hdr_nx[7];
   end

   // advance on an accepted byte, return to reset state after the final one
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      alen_in  = alen_ff;
      hdr_in   = hdr_ff;
      rem_in   = rem_ff;
      err_in   = err_ff;
      if (accept) begin
         if (req_if.final_byte) begin
            phase_in = PH_SALT;
            cnt_in   = '0;
            shift_in = '0;
            alen_in  = '0;
            for (int i = 0; i < 8; i++) begin
               hdr_in[i] = '0;
            end
            rem_in   = '0;
            err_in   = '0;
         end else begin
            phase_in = ph_nx;
            cnt_in   = cnt_nx;
            shift_in = shift_nx;
            alen_in  = alen_nx;
            hdr_in   = hdr_nx;
            rem_in   = rem_nx;
            err_in   = err_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SALT;
         cnt_ff   <= '0;
         shift_ff <= '0;
         alen_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            hdr_ff[i] <= '0;
         end
         rem_ff   <= '0;
         err_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         alen_ff  <= alen_in;
         hdr_ff   <= hdr_in;
         rem_ff   <= rem_in;
         err_ff   <= err_in;
      end
   end

   // result queue: payload item first, then the summary
   assign push_pay = accept & pay_hit;
   assign push_sum = accept & req_if.final_byte;
   assign sum_addr = wr_ff + AW'(push_pay);

   always_comb begin
      wr_in    = wr_ff + AW'(push_pay) + AW'(push_sum);
      rd_in    = rd_ff + AW'(pop);
      count_in = count_ff - (AW+1)'(pop) + (AW+1)'(push_pay) + (AW+1)'(push_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_pay) begin
         q_ff[wr_ff] <= pay_rsp;
      end
      if (push_sum) begin
         q_ff[sum_addr] <= sum_rsp;
      end
   end

   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.kind         = q_ff[rd_ff].kind;
   assign rsp_if.payload_byte = q_ff[rd_ff].payload_byte;
   assign rsp_if.status       = q_ff[rd_ff].status;
   assign rsp_if.addr_present = q_ff[rd_ff].addr_present;
   assign rsp_if.origin_addr  = q_ff[rd_ff].origin_addr;
   assign rsp_if.encode_time  = q_ff[rd_ff].encode_time;
   assign rsp_if.time_to_live = q_ff[rd_ff].time_to_live;
   assign rsp_if.user_id      = q_ff[rd_ff].user_id;
   assign rsp_if.group_id     = q_ff[rd_ff].group_id;
   assign rsp_if.allowed_uid  = q_ff[rd_ff].allowed_uid;
   assign rsp_if.allowed_gid  = q_ff[rd_ff].allowed_gid;
   assign rsp_if.data_length  = q_ff[rd_ff].data_length;

endmodule

`default_nettype wire

// ----- sv/cip_checker.sv -----
// ----------------------------------------------------------------------------
// cip_checker
// Port-level checks on the inner credential unpacker, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module cip_checker (
   input  wire       clock,
   input  wire       reset,
   cip_req_if.sink   req_if,
   cip_rsp_if.source rsp_if
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=>
         rsp_if.valid && $stable(rsp_if.kind) && $stable(rsp_if.payload_byte) &&
         $stable(rsp_if.status) && $stable(rsp_if.data_length))
      else $error("result item changed while stalled");

   // payload items carry nothing but the byte
   a_pay_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == cip_pkg::KIND_PAYLOAD |->
         rsp_if.status == cip_pkg::ST_OK && !rsp_if.addr_present &&
         rsp_if.origin_addr == 32'd0 && rsp_if.data_length == 32'd0)
      else $error("payload item with header fields set");

   // summaries carry no byte and a known status
   a_sum_status: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == cip_pkg::KIND_SUMMARY |->
         rsp_if.payload_byte == 8'd0 && rsp_if.status <= cip_pkg::ST_TRAILING)
      else $error("summary with byte or unknown status");

   // an absent address reads as zero
   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == cip_pkg::KIND_SUMMARY &&
         !rsp_if.addr_present |-> rsp_if.origin_addr == 32'd0)
      else $error("origin address without address present");

   // an accepted final byte leaves a summary queued for the next cycle
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.final_byte |=> rsp_if.valid)
      else $error("final byte produced no summary");

endmodule

bind credential_inner_unpacker cip_checker u_cip_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

`default_nettype wire

// ----- tb/tb_credential_inner_unpacker.sv -----
// ----------------------------------------------------------------------------
// tb_credential_inner_unpacker
// Self-checking bench for the inner credential unpacker. A table of
// credential shapes is sent first, covering truncation in most fields, bad
// address lengths, the counter saturation, zero and full header words and
// trailing bytes. Random credentials follow, mostly well formed with random
// content, the rest noise. Every accepted byte runs through a local parser
// model. Each result item is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_credential_inner_unpacker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILL_ZERO    = 0;
   localparam int FILL_ONES    = 1;
   localparam int FILL_RAND    = 2;
   localparam int BY_MODEL     = -1;
   localparam int RANDOM_ITEMS = 370;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 45;
   localparam int N_ROWS       = 23;

   typedef enum logic [3:0] {
      SEEK_SALT, SEEK_ALEN, SEEK_ADDR, SKIP_BADADDR,
      WORD_ENC, WORD_TTL, WORD_UID, WORD_GID, WORD_AUID, WORD_AGID, WORD_DLEN,
      IN_PAYLOAD, CLOSED
   } scan_phase_type;

   typedef struct {
      int          len;
      logic [7:0]  alen;
      logic [31:0] dlen;
      int          fill;
      int          status;
   } cred_shape_type;

   // total length, address length byte, data length, fill, status or BY_MODEL
   cred_shape_type shapes [N_ROWS] = '{
      '{1,   8'd0,   32'd0,         FILL_RAND, cip_pkg::ST_SALT_SHORT},
      '{8,   8'd0,   32'd0,         FILL_ONES, cip_pkg::ST_ALEN_SHORT},
      '{9,   8'd0,   32'd0,         FILL_RAND, cip_pkg::ST_WORD0_SHORT},
      '{11,  8'd4,   32'd0,         FILL_ONES, cip_pkg::ST_ADDR_SHORT},
      '{13,  8'd4,   32'd0,         FILL_ONES, cip_pkg::ST_WORD0_SHORT},
      '{12,  8'd7,   32'd0,         FILL_RAND, cip_pkg::ST_ADDR_SHORT},
      '{10,  8'd1,   32'd0,         FILL_RAND, cip_pkg::ST_ADDR_BAD},
      '{12,  8'd3,   32'd0,         FILL_RAND, cip_pkg::ST_ADDR_BAD},
      '{13,  8'd5,   32'd0,         FILL_RAND, cip_pkg::ST_ADDR_SHORT},
      '{14,  8'd5,   32'd0,         FILL_RAND, cip_pkg::ST_ADDR_BAD},
      '{9,   8'd255, 32'd0,         FILL_ONES, cip_pkg::ST_ADDR_SHORT},
      '{264, 8'd255, 32'd0,         FILL_RAND, cip_pkg::ST_ADDR_BAD},
      '{300, 8'd255, 32'd0,         FILL_RAND, cip_pkg::ST_ADDR_BAD},
      '{37,  8'd0,   32'd0,         FILL_ZERO, cip_pkg::ST_OK},
      '{41,  8'd4,   32'd0,         FILL_ONES, cip_pkg::ST_OK},
      '{44,  8'd4,   32'd3,         FILL_ONES, cip_pkg::ST_OK},
      '{46,  8'd4,   32'hFFFF_FFFF, FILL_ONES, cip_pkg::ST_PAY_SHORT},
      '{48,  8'd4,   32'd2,         FILL_RAND, cip_pkg::ST_TRAILING},
      '{42,  8'd4,   32'd1,         FILL_RAND, cip_pkg::ST_OK},
      '{27,  8'd4,   32'd0,         FILL_RAND, BY_MODEL},
      '{34,  8'd0,   32'd0,         FILL_RAND, BY_MODEL},
      '{45,  8'd0,   32'd8,         FILL_RAND, BY_MODEL},
      '{43,  8'd4,   32'd0,         FILL_RAND, BY_MODEL}
   };

   logic clock;
   logic reset;

   cip_req_if req_bus ();
   cip_rsp_if rsp_bus ();

   credential_inner_unpacker u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // parser model state
   scan_phase_type p_phase;
   logic [7:0]     p_count;
   logic [31:0]    p_accum;
   logic [7:0]     p_alen;
   logic [31:0]    p_words [8];
   logic [31:0]    p_left;
   logic           p_trailing;

   cip_pkg::rsp_type due_results [$];
   logic [7:0]       cred_bytes [$];
   int               mismatches   = 0;
   int               results_seen = 0;
   int               items_sent   = 0;
   int               gap_mode     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic clear_parser();
      p_phase    = SEEK_SALT;
      p_count    = '0;
      p_accum    = '0;
      p_alen     = '0;
      p_left     = '0;
      p_trailing = 1'b0;
      foreach (p_words[i]) p_words[i] = '0;
   endtask

   // advance the parser by one byte and queue the results it causes
   task automatic unpack_byte(input logic [7:0] b, input logic last, input int typed);
      cip_pkg::rsp_type item;
      logic             have_addr;
      int               slot;

      if (p_phase == SEEK_SALT && p_count >= cip_pkg::SALT_BYTES) begin
         p_phase = SEEK_ALEN;
         p_count = '0;
      end

      case (p_phase)
         SEEK_SALT: begin
            p_count++;
            if (p_count >= cip_pkg::SALT_BYTES) begin
               p_phase = SEEK_ALEN;
               p_count = '0;
            end
         end
         SEEK_ALEN: begin
            p_alen  = b;
            p_count = '0;
            p_accum = '0;
            if (b == 8'd0) p_phase = WORD_ENC;
            else if (b == cip_pkg::ADDR_BYTES) p_phase = SEEK_ADDR;
            else p_phase = SKIP_BADADDR;
         end
         SKIP_BADADDR: begin
            if (p_count != 8'hFF) p_count++;
         end
         IN_PAYLOAD: begin
            item = '0;
            item.kind = cip_pkg::KIND_PAYLOAD;
            item.payload_byte = b;
            due_results.push_back(item);
            p_left--;
            if (p_left == 0) p_phase = CLOSED;
         end
         CLOSED: begin
            p_trailing = 1'b1;
         end
         default: begin
            // address or one of the header words
            p_accum = {p_accum[23:0], b};
            p_count++;
            if (p_count >= cip_pkg::WORD_BYTES) begin
               slot = (p_phase == SEEK_ADDR) ? 0 : int'(p_phase) - int'(WORD_ENC) + 1;
               p_words[slot] = p_accum;
               p_count = '0;
               if (p_phase == WORD_DLEN) begin
                  if (p_accum == 0) begin
                     p_phase = CLOSED;
                  end else begin
                     p_left  = p_accum;
                     p_phase = IN_PAYLOAD;
                  end
               end else if (p_phase == SEEK_ADDR) begin
                  p_phase = WORD_ENC;
               end else begin
                  p_phase = scan_phase_type'(int'(p_phase) + 1);
               end
               p_accum = '0;
            end
         end
      endcase

      if (last) begin
         have_addr = (p_alen == cip_pkg::ADDR_BYTES) && (p_phase >= WORD_ENC);
         item = '0;
         item.kind = cip_pkg::KIND_SUMMARY;
         case (p_phase)
            SEEK_SALT:    item.status = cip_pkg::ST_SALT_SHORT;
            SEEK_ALEN:    item.status = cip_pkg::ST_ALEN_SHORT;
            SEEK_ADDR:    item.status = cip_pkg::ST_ADDR_SHORT;
            SKIP_BADADDR: item.status = (p_alen > p_count) ? cip_pkg::ST_ADDR_SHORT
                                                           : cip_pkg::ST_ADDR_BAD;
            IN_PAYLOAD:   item.status = cip_pkg::ST_PAY_SHORT;
            CLOSED:       item.status = p_trailing ? cip_pkg::ST_TRAILING : cip_pkg::ST_OK;
            default:      item.status = cip_pkg::ST_WORD0_SHORT +
                                        4'(int'(p_phase) - int'(WORD_ENC));
         endcase
         if (typed != BY_MODEL) item.status = typed[3:0];
         item.addr_present = have_addr;
         item.origin_addr  = have_addr ? p_words[0] : '0;
         item.encode_time  = p_words[1];
         item.time_to_live = p_words[2];
         item.user_id      = p_words[3];
         item.group_id     = p_words[4];
         item.allowed_uid  = p_words[5];
         item.allowed_gid  = p_words[6];
         item.data_length  = p_words[7];
         due_results.push_back(item);
         clear_parser();
      end
   endtask

   function automatic logic [7:0] fill_byte(input int fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // lay out one credential and pad or cut it to len bytes
   task automatic compose_credential(input logic [7:0] alen, input logic [31:0] dlen,
                                     input int fill, input int len);
      longint k;

      cred_bytes.delete();
      repeat (int'(cip_pkg::SALT_BYTES)) cred_bytes.push_back(fill_byte(fill));
      cred_bytes.push_back(alen);
      if (alen == 8'd0 || alen == cip_pkg::ADDR_BYTES) begin
         if (alen == cip_pkg::ADDR_BYTES) repeat (4) cred_bytes.push_back(fill_byte(fill));
         repeat (24) cred_bytes.push_back(fill_byte(fill));
         for (int i = 3; i >= 0; i--) cred_bytes.push_back(dlen[8*i +: 8]);
         for (k = 0; k < longint'(dlen) && cred_bytes.size() < len; k++)
            cred_bytes.push_back(fill_byte(fill));
      end
      while (cred_bytes.size() < len) cred_bytes.push_back(8'($urandom_range(0, 255)));
      while (cred_bytes.size() > len) void'(cred_bytes.pop_back());
   endtask

   // entered and left at a rising edge; the byte is accepted at the exit edge
   task automatic send_byte(input logic [7:0] b, input logic last, input int typed);
      int gap;

      gap = 0;
      if (gap_mode != 0 && $urandom_range(0, 99) < (gap_mode == 1 ? 10 : 35))
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 2);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_in    <= b;
      req_bus.final_byte <= last;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      items_sent++;
      unpack_byte(b, last, typed);
   endtask

   task automatic send_credential(input int typed);
      gap_mode = $urandom_range(0, 2);
      foreach (cred_bytes[i]) send_byte(cred_bytes[i], i == cred_bytes.size() - 1, typed);
   endtask

   task automatic wait_drained();
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb: mismatch on %s: expected %h, got %h", name, want, got);
      end
   endtask

   // stimulus
   initial begin : req_drive
      int          base;
      int          n_creds;
      int          pick;
      int          len;
      int          hdr;
      int          fill;
      logic [7:0]  alen;
      logic [31:0] dlen;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_in    = '0;
      req_bus.final_byte = 1'b0;
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (shapes[i]) begin
         compose_credential(shapes[i].alen, shapes[i].dlen, shapes[i].fill, shapes[i].len);
         send_credential(shapes[i].status);
      end
      req_bus.valid <= 1'b0;
      wait_drained();

      base    = items_sent;
      n_creds = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         fill = ($urandom_range(0, 9) == 0) ? $urandom_range(FILL_ZERO, FILL_ONES) : FILL_RAND;
         if (pick < 75) begin
            alen = $urandom_range(0, 1) ? cip_pkg::ADDR_BYTES : 8'd0;
            dlen = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
            hdr  = 37 + int'(alen);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               len = hdr + int'(dlen);
            end else if (pick < 8) begin
               len = hdr + int'(dlen) + $urandom_range(1, 4);
            end else if ($urandom_range(0, 1) == 0) begin
               len = $urandom_range(1, hdr + int'(dlen));
            end else begin
               dlen = $urandom();
               if (dlen == 0) dlen = 32'd1;
               len = hdr + $urandom_range(0, 6);
            end
         end else begin
            alen = 8'($urandom_range(0, 255));
            dlen = $urandom_range(0, 6);
            len  = $urandom_range(1, 40);
         end
         compose_credential(alen, dlen, fill, len);
         send_credential(BY_MODEL);
         n_creds++;
         if (n_creds == 10) begin
            req_bus.valid <= 1'b0;
            wait_drained();
         end
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // result side back-pressure
   initial begin : rsp_drive
      int   stall_left;
      int   mode;
      int   window;
      logic long_done;

      stall_left    = 0;
      mode          = 0;
      window        = 0;
      long_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (window == 0) begin
            mode   = $urandom_range(0, 2);
            window = $urandom_range(50, 300);
         end
         window--;
         // hold off long enough for the block to fill and stall its input
         if (!long_done && results_seen >= HOLD_AFTER) begin
            stall_left = LONG_HOLD;
            long_done  = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (mode != 0 && $urandom_range(0, 99) < (mode == 1 ? 10 : 35)) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // sample mid-cycle; a handshake seen here completes at the next rising edge
   always @(negedge clock) begin : rsp_check
      cip_pkg::rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected item, kind %b byte %h status %0d",
                        rsp_bus.kind, rsp_bus.payload_byte, rsp_bus.status);
         end else begin
            want = due_results.pop_front();
            check_field("kind",         32'(want.kind),         32'(rsp_bus.kind));
            check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_bus.payload_byte));
            check_field("status",       32'(want.status),       32'(rsp_bus.status));
            check_field("addr_present", 32'(want.addr_present), 32'(rsp_bus.addr_present));
            check_field("origin_addr",  want.origin_addr,  rsp_bus.origin_addr);
            check_field("encode_time",  want.encode_time,  rsp_bus.encode_time);
            check_field("time_to_live", want.time_to_live, rsp_bus.time_to_live);
            check_field("user_id",      want.user_id,      rsp_bus.user_id);
            check_field("group_id",     want.group_id,     rsp_bus.group_id);
            check_field("allowed_uid",  want.allowed_uid,  rsp_bus.allowed_uid);
            check_field("allowed_gid",  want.allowed_gid,  rsp_bus.allowed_gid);
            check_field("data_length",  want.data_length,  rsp_bus.data_length);
         end
      end
   end

endmodule
